FILE: design/bankers_safety_check_top_macros.svh
// Assertion macros used by the checker file of the safety check block.
`ifndef BANKERS_SAFETY_CHECK_TOP_MACROS_SVH
`define BANKERS_SAFETY_CHECK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bsc_pkg.sv
// Package of the safety check block: payload types, opcodes, register indexes, sizes.
`default_nettype none

package bsc_pkg;

   // default sizes
   localparam int NUM_PROCESSES_DEF = 4;
   localparam int NUM_RESOURCES_DEF = 3;
   localparam int UNIT_WIDTH_DEF    = 8;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int PIDX_W     = 2;
   localparam int RIDX_W     = 2;
   localparam int LABEL_W    = 8;
   localparam int FIELD_W    = 8;
   localparam int POS_W      = 2;
   localparam int ACT_PROC_W = 3;
   localparam int ACT_RES_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   // opcodes
   localparam logic [OP_W-1:0] OP_LOAD_FREE  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_ENTRY = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK      = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PROCESSES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_RESOURCES = 1'd1;

   // register reset values
   localparam logic [ACT_PROC_W-1:0] ACT_PROC_RST = 3'd4;
   localparam logic [ACT_RES_W-1:0]  ACT_RES_RST  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [PIDX_W-1:0]  proc_index;
      logic [RIDX_W-1:0]  res_index;
      logic [LABEL_W-1:0] proc_label;
      logic [FIELD_W-1:0] max_claim;
      logic [FIELD_W-1:0] held;
      logic [FIELD_W-1:0] avail_amount;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] seq_label;
      logic [POS_W-1:0]   seq_position;
      logic               safe;
      logic               last;
   } rsp_type;

   // configuration seen by the engine
   typedef struct packed {
      logic [ACT_PROC_W-1:0] active_processes;
      logic [ACT_RES_W-1:0]  active_resources;
   } cfg_type;

endpackage

`default_nettype wire

FILE: design/bsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/bsc_engine.sv
// Check sequencer: load decode, row/column scan over the entry RAM, work vector, result output.
`default_nettype none

module bsc_engine #(
   parameter int NUM_PROCESSES = bsc_pkg::NUM_PROCESSES_DEF,
   parameter int NUM_RESOURCES = bsc_pkg::NUM_RESOURCES_DEF,
   parameter int UNIT_WIDTH    = bsc_pkg::UNIT_WIDTH_DEF,
   localparam int PW   = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1,
   localparam int CW   = $clog2(NUM_PROCESSES + 1),
   localparam int RW   = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1,
   localparam int RCW  = $clog2(NUM_RESOURCES + 1),
   localparam int CELLS = NUM_PROCESSES * NUM_RESOURCES,
   localparam int AW   = (CELLS > 1) ? $clog2(CELLS) : 1,
   localparam int EW   = 2 * UNIT_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bsc_pkg::cfg_type             cfg,
   input  wire logic                         start,
   input  wire bsc_pkg::req_type             req,
   output logic                              busy,
   output logic                              rsp_strobe,
   output bsc_pkg::rsp_type                  rsp,
   // entry RAM: {claim, held}
   output logic                              entry_we,
   output logic      [AW-1:0]                entry_waddr,
   output logic      [EW-1:0]                entry_wdata,
   output logic      [AW-1:0]                entry_raddr,
   input  wire logic [EW-1:0]                entry_rdata,
   // label RAM
   output logic                              label_we,
   output logic      [PW-1:0]                label_waddr,
   output logic      [bsc_pkg::LABEL_W-1:0]  label_wdata,
   output logic      [PW-1:0]                label_raddr,
   input  wire logic [bsc_pkg::LABEL_W-1:0]  label_rdata
);

   // work needs room for the free amount plus every holding
   localparam int WW    = UNIT_WIDTH + $clog2(NUM_PROCESSES + 1);
   localparam int SUM_W = WW + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_ROW,
      S_READ,
      S_EVAL,
      S_COMMIT,
      S_PASS_END,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [PW-1:0]           row_ff, row_in;
   logic [AW-1:0]           row_base_ff, row_base_in;
   logic [RW-1:0]           col_ff, col_in;
   logic [CW-1:0]           done_ff, done_in;
   logic [CW-1:0]           np_ff, np_in;
   logic [RCW-1:0]          nr_ff, nr_in;
   logic                    progress_ff, progress_in;
   logic                    fit_ff, fit_in;
   logic [PW-1:0]           emit_ff, emit_in;
   logic [NUM_PROCESSES-1:0] fin_ff, fin_in;
   logic [PW-1:0]           order_ff [NUM_PROCESSES];
   logic [PW-1:0]           order_in [NUM_PROCESSES];
   logic [WW-1:0]           work_ff  [NUM_RESOURCES];
   logic [WW-1:0]           work_in  [NUM_RESOURCES];
   logic [UNIT_WIDTH-1:0]   free_ff  [NUM_RESOURCES];
   logic [UNIT_WIDTH-1:0]   free_in  [NUM_RESOURCES];
   logic [UNIT_WIDTH-1:0]   hold_ff  [NUM_RESOURCES];
   logic [UNIT_WIDTH-1:0]   hold_in  [NUM_RESOURCES];
   logic                    rsp_strobe_ff, rsp_strobe_in;
   bsc_pkg::rsp_type        rsp_ff, rsp_in;

   // clamped active counts
   logic [CW-1:0]           np_clamp;
   logic [RCW-1:0]          nr_clamp;

   always_comb begin
      if (cfg.active_processes == '0) begin
         np_clamp = CW'(1);
      end else if (int'(cfg.active_processes) > NUM_PROCESSES) begin
         np_clamp = CW'(NUM_PROCESSES);
      end else begin
         np_clamp = CW'(cfg.active_processes);
      end
      if (cfg.active_resources == '0) begin
         nr_clamp = RCW'(1);
      end else if (int'(cfg.active_resources) > NUM_RESOURCES) begin
         nr_clamp = RCW'(NUM_RESOURCES);
      end else begin
         nr_clamp = RCW'(cfg.active_resources);
      end
   end

   // load decode: write ports of both RAMs
   logic load_ok;

   assign load_ok     = (int'(req.proc_index) < NUM_PROCESSES) &&
                        (int'(req.res_index) < NUM_RESOURCES);
   assign entry_we    = (state_ff == S_IDLE) && start &&
                        (req.op == bsc_pkg::OP_LOAD_ENTRY) && load_ok;
   assign label_we    = entry_we;
   assign entry_waddr = AW'(int'(req.proc_index) * NUM_RESOURCES + int'(req.res_index));
   assign entry_wdata = {UNIT_WIDTH'(req.max_claim), UNIT_WIDTH'(req.held)};
   assign label_waddr = PW'(req.proc_index);
   assign label_wdata = req.proc_label;

   // read addresses follow the scan position
   assign entry_raddr = row_base_ff + AW'(col_ff);
   assign label_raddr = order_ff[emit_ff];

   // next-state logic
   always_comb begin
      logic [UNIT_WIDTH-1:0] claim_v;
      logic [UNIT_WIDTH-1:0] held_v;
      logic                  row_last;

      state_in      = state_ff;
      row_in        = row_ff;
      row_base_in   = row_base_ff;
      col_in        = col_ff;
      done_in       = done_ff;
      np_in         = np_ff;
      nr_in         = nr_ff;
      progress_in   = progress_ff;
      fit_in        = fit_ff;
      emit_in       = emit_ff;
      fin_in        = fin_ff;
      order_in      = order_ff;
      work_in       = work_ff;
      free_in       = free_ff;
      hold_in       = hold_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      claim_v  = entry_rdata[EW-1:UNIT_WIDTH];
      held_v   = entry_rdata[UNIT_WIDTH-1:0];
      row_last = ((CW'(row_ff) + CW'(1)) == np_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req.op)
                  bsc_pkg::OP_LOAD_FREE: begin
                     if (int'(req.res_index) < NUM_RESOURCES) begin
                        free_in[RW'(req.res_index)] = UNIT_WIDTH'(req.avail_amount);
                     end
                  end
                  bsc_pkg::OP_CHECK: begin
                     state_in = S_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // copy free into work, clear flags and order
         S_INIT: begin
            np_in       = np_clamp;
            nr_in       = nr_clamp;
            fin_in      = '0;
            done_in     = '0;
            row_in      = '0;
            row_base_in = '0;
            progress_in = 1'b0;
            for (int c = 0; c < NUM_RESOURCES; c++) begin
               work_in[c] = (c < int'(nr_clamp)) ? WW'(free_ff[c]) : '0;
            end
            for (int p = 0; p < NUM_PROCESSES; p++) begin
               order_in[p] = '0;
            end
            state_in = S_ROW;
         end

         // skip finished rows, start the column scan of an open row
         S_ROW: begin
            if (fin_ff[row_ff]) begin
               if (row_last) begin
                  state_in = S_PASS_END;
               end else begin
                  row_in      = row_ff + PW'(1);
                  row_base_in = row_base_ff + AW'(NUM_RESOURCES);
               end
            end else begin
               col_in   = '0;
               fit_in   = 1'b1;
               state_in = S_READ;
            end
         end

         S_READ: begin
            state_in = S_EVAL;
         end

         // need > work  <=>  claim > work + held
         S_EVAL: begin
            if (SUM_W'(claim_v) > (SUM_W'(work_ff[col_ff]) + SUM_W'(held_v))) begin
               fit_in = 1'b0;
            end
            hold_in[col_ff] = held_v;
            if ((RCW'(col_ff) + RCW'(1)) == nr_ff) begin
               state_in = S_COMMIT;
            end else begin
               col_in   = col_ff + RW'(1);
               state_in = S_READ;
            end
         end

         // release a fitting row's holdings into work at once, then move to the next row
         S_COMMIT: begin
            if (fit_ff) begin
               for (int c = 0; c < NUM_RESOURCES; c++) begin
                  if (c < int'(nr_ff)) begin
                     work_in[c] = work_ff[c] + WW'(hold_ff[c]);
                  end
               end
               order_in[done_ff[PW-1:0]] = row_ff;
               done_in                   = done_ff + CW'(1);
               fin_in[row_ff]            = 1'b1;
               progress_in               = 1'b1;
            end
            if (row_last) begin
               state_in = S_PASS_END;
            end else begin
               row_in      = row_ff + PW'(1);
               row_base_in = row_base_ff + AW'(NUM_RESOURCES);
               state_in    = S_ROW;
            end
         end

         S_PASS_END: begin
            if (done_ff == np_ff) begin
               emit_in  = '0;
               state_in = S_EMIT_RD;
            end else if (!progress_ff) begin
               // unsafe: one zeroed result marked last
               rsp_in.seq_label    = '0;
               rsp_in.seq_position = '0;
               rsp_in.safe         = 1'b0;
               rsp_in.last         = 1'b1;
               rsp_strobe_in       = 1'b1;
               state_in            = S_IDLE;
            end else begin
               row_in      = '0;
               row_base_in = '0;
               progress_in = 1'b0;
               state_in    = S_ROW;
            end
         end

         S_EMIT_RD: begin
            state_in = S_EMIT_OUT;
         end

         S_EMIT_OUT: begin
            rsp_in.seq_label    = label_rdata;
            rsp_in.seq_position = bsc_pkg::POS_W'(emit_ff);
            rsp_in.last         = ((CW'(emit_ff) + CW'(1)) == np_ff);
            rsp_in.safe         = rsp_in.last;
            rsp_strobe_in       = 1'b1;
            if (rsp_in.last) begin
               state_in = S_IDLE;
            end else begin
               emit_in  = emit_ff + PW'(1);
               state_in = S_EMIT_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      row_base_ff <= row_base_in;
      col_ff      <= col_in;
      done_ff     <= done_in;
      np_ff       <= np_in;
      nr_ff       <= nr_in;
      progress_ff <= progress_in;
      fit_ff      <= fit_in;
      emit_ff     <= emit_in;
      free_ff     <= free_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         fin_ff        <= '0;
         for (int c = 0; c < NUM_RESOURCES; c++) begin
            work_ff[c] <= '0;
         end
         for (int p = 0; p < NUM_PROCESSES; p++) begin
            order_ff[p] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fin_ff        <= fin_in;
         work_ff       <= work_in;
         order_ff      <= order_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

FILE: design/bankers_safety_check_top.sv
// Top level of the safety check block: register port, state RAMs and check sequencer.
//
// Request channel: a request is taken at a rising edge with start high and busy low.
//   Load requests (free amount, process entry) leave busy low.
//   A check request raises busy until its last result has been driven.
// Result channel: each result is on rsp_data for one cycle with rsp_strobe high;
//   the receiver cannot stall it. A safe check gives one result per active process
//   in safe order, safe and last set on the final one; an unsafe check gives one
//   result with safe clear and last set.
// Check sequence: setup, then passes over the active rows; each pass skips finished
//   rows, scans each open row column by column (R active resources), and ends with
//   a pass-end step; then the results are emitted. The entry RAM read port, one
//   column at a time, sets the scan time. Up to P passes for P active processes.
// Register port: csr_index selects active_processes (0) or active_resources (1);
//   writes are taken while the block is not busy.
// Reset (synchronous, active high) returns to idle, clears the strobe and sets the
//   registers to 4 processes and 3 resources. RAM contents are not cleared; a
//   check must only read entries that were loaded.
`default_nettype none

module bankers_safety_check_top #(
   parameter int NUM_PROCESSES = bsc_pkg::NUM_PROCESSES_DEF,
   parameter int NUM_RESOURCES = bsc_pkg::NUM_RESOURCES_DEF,
   parameter int UNIT_WIDTH    = bsc_pkg::UNIT_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // requests
   input  wire logic                            start,
   input  wire bsc_pkg::req_type                req_data,
   output logic                                 busy,
   // results
   output logic                                 rsp_strobe,
   output bsc_pkg::rsp_type                     rsp_data,
   // registers
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int CELLS = NUM_PROCESSES * NUM_RESOURCES;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int EW    = 2 * UNIT_WIDTH;

   // configuration registers
   logic [bsc_pkg::ACT_PROC_W-1:0] act_proc_ff, act_proc_in;
   logic [bsc_pkg::ACT_RES_W-1:0]  act_res_ff, act_res_in;
   bsc_pkg::cfg_type               cfg;

   assign csr_ready = ~busy;

   always_comb begin
      act_proc_in = act_proc_ff;
      act_res_in  = act_res_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bsc_pkg::CSR_ACTIVE_PROCESSES: act_proc_in = csr_wdata[bsc_pkg::ACT_PROC_W-1:0];
            bsc_pkg::CSR_ACTIVE_RESOURCES: act_res_in  = csr_wdata[bsc_pkg::ACT_RES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_proc_ff <= bsc_pkg::ACT_PROC_RST;
         act_res_ff  <= bsc_pkg::ACT_RES_RST;
      end else begin
         act_proc_ff <= act_proc_in;
         act_res_ff  <= act_res_in;
      end
   end

   assign cfg.active_processes = act_proc_ff;
   assign cfg.active_resources = act_res_ff;

   // RAM connections
   logic                        entry_we;
   logic [AW-1:0]               entry_waddr;
   logic [EW-1:0]               entry_wdata;
   logic [AW-1:0]               entry_raddr;
   logic [EW-1:0]               entry_rdata;
   logic                        label_we;
   logic [PW-1:0]               label_waddr;
   logic [bsc_pkg::LABEL_W-1:0] label_wdata;
   logic [PW-1:0]               label_raddr;
   logic [bsc_pkg::LABEL_W-1:0] label_rdata;

   // claim and holding per process and resource
   bsc_ram #(
      .DATA_W (EW),
      .DEPTH  (CELLS)
   ) u_entry_ram (
      .clock (clock),
      .we    (entry_we),
      .waddr (entry_waddr),
      .wdata (entry_wdata),
      .raddr (entry_raddr),
      .rdata (entry_rdata)
   );

   // label per process
   bsc_ram #(
      .DATA_W (bsc_pkg::LABEL_W),
      .DEPTH  (NUM_PROCESSES)
   ) u_label_ram (
      .clock (clock),
      .we    (label_we),
      .waddr (label_waddr),
      .wdata (label_wdata),
      .raddr (label_raddr),
      .rdata (label_rdata)
   );

   bsc_engine #(
      .NUM_PROCESSES (NUM_PROCESSES),
      .NUM_RESOURCES (NUM_RESOURCES),
      .UNIT_WIDTH    (UNIT_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .start       (start),
      .req         (req_data),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp_data),
      .entry_we    (entry_we),
      .entry_waddr (entry_waddr),
      .entry_wdata (entry_wdata),
      .entry_raddr (entry_raddr),
      .entry_rdata (entry_rdata),
      .label_we    (label_we),
      .label_waddr (label_waddr),
      .label_wdata (label_wdata),
      .label_raddr (label_raddr),
      .label_rdata (label_rdata)
   );

endmodule

`default_nettype wire

FILE: design/bsc_checker.sv
// Port-level checks of the safety check block and their binding to the top level.
`default_nettype none
`include "bankers_safety_check_top_macros.svh"

module bsc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire bsc_pkg::req_type req_data,
   input wire logic             rsp_strobe,
   input wire bsc_pkg::rsp_type rsp_data
);

   // loads and unused opcodes finish in the cycle they are taken
   `BSC_ASSERT_NEXT(a_load_one_cycle, clock, reset, start && !busy && (req_data.op != bsc_pkg::OP_CHECK), !busy, "load request left the block busy")
   // a check request occupies the block
   `BSC_ASSERT_NEXT(a_check_busy, clock, reset, start && !busy && (req_data.op == bsc_pkg::OP_CHECK), busy, "check request did not raise busy")
   // results only come out of a running check
   `BSC_ASSERT_NOW(a_rsp_from_check, clock, reset, rsp_strobe, $past(busy), "result strobe without a running check")
   // more results follow a non-final one
   `BSC_ASSERT_NOW(a_rsp_more, clock, reset, rsp_strobe && !rsp_data.last, busy, "block went idle before the final result")
   // the final result is a single strobe
   `BSC_ASSERT_NEXT(a_last_ends, clock, reset, rsp_strobe && rsp_data.last, !rsp_strobe, "result strobe after the final result")

endmodule

bind bankers_safety_check_top bsc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
